### rtl/srlc_pkg.sv
package srlc_pkg;

    // default fraction width of rates, gains, integral and torque
    localparam int FRAC_BITS_DEF = 16;
    // fraction width of the time step
    localparam int DT_FRAC_BITS = 24;

    localparam int DATA_W  = 32;
    localparam int DT_W    = 24;
    localparam int CLAMP_W = 31;
    localparam int CFG_IDX_W = 3;

    localparam logic [CLAMP_W-1:0] CLAMP_RESET = CLAMP_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN = 3'd0,
        REG_INT_GAIN  = 3'd1,
        REG_INT_CLAMP = 3'd2,
        REG_POS_SAT   = 3'd3,
        REG_NEG_SAT   = 3'd4
    } cfg_reg_t;

endpackage

### rtl/servo_lqr_rate_controller_top.sv
// Rate servo controller with integral action and anti-windup. Each request on the slave
// stream carries a measured rate, a target rate, a time step and an on-ground flag, and
// produces one torque command, -kp*rate - ki*integral, saturated to 32 bits, using the
// integral from before that request; when not on ground the integral then takes
// (rate - target)*dt and is clamped to +-integral_clamp, with the saturation flags
// blocking error of one sign. The block takes one request per cycle while the master
// side does not stall. A request passes the input, product and result registers in
// that order and is presented from the result register. The rate is set by the
// integral accumulator, whose add-and-clamp is combinational. A stall on the master
// side holds the whole pipeline. Gains, clamp and flags must be written through the
// configuration port while no request is in flight; the block does not enforce it.
module servo_lqr_rate_controller_top #(
    parameter int FRAC_BITS = srlc_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [srlc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srlc_pkg::DATA_W-1:0]    cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // measured_rate [31:0], target_rate [63:32], time_step [87:64]
    input  logic [87:0]                    s_axis_tdata,
    // on_ground [0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // torque_command [31:0]
    output logic [srlc_pkg::DATA_W-1:0]    m_axis_tdata
);

    localparam int DW    = srlc_pkg::DATA_W;
    localparam int DTW   = srlc_pkg::DT_W;
    localparam int CW    = srlc_pkg::CLAMP_W;
    localparam int PT_W  = 2 * DW - FRAC_BITS;      // floor-shifted gain product
    localparam int TQ_W  = PT_W + 2;                // negated sum of two terms
    localparam int ERR_W = DW + 1;
    localparam int EP_W  = ERR_W + DTW + 1;         // error times unsigned dt
    localparam int ED_W  = EP_W - srlc_pkg::DT_FRAC_BITS;
    localparam int IS_W  = ED_W + 1;                // integral plus increment

    // configuration
    logic signed [DW-1:0] kp_reg;
    logic signed [DW-1:0] ki_reg;
    logic [CW-1:0]        clamp_reg;
    logic                 pos_sat_reg;
    logic                 neg_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg      <= '0;
            ki_reg      <= '0;
            clamp_reg   <= srlc_pkg::CLAMP_RESET;
            pos_sat_reg <= 1'b0;
            neg_sat_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                srlc_pkg::REG_PROP_GAIN: kp_reg      <= cfg_data;
                srlc_pkg::REG_INT_GAIN:  ki_reg      <= cfg_data;
                srlc_pkg::REG_INT_CLAMP: clamp_reg   <= cfg_data[CW-1:0];
                srlc_pkg::REG_POS_SAT:   pos_sat_reg <= cfg_data[0];
                srlc_pkg::REG_NEG_SAT:   neg_sat_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances together unless the result is stalled
    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // stage a: input register
    logic                  a_valid_reg;
    logic signed [DW-1:0]  a_meas_reg;
    logic signed [DW-1:0]  a_target_reg;
    logic [DTW-1:0]        a_dt_reg;
    logic                  a_ground_reg;

    // stage b: products
    logic                  b_valid_reg;
    logic signed [PT_W-1:0] b_pterm_reg;
    logic signed [ED_W-1:0] b_edt_reg;
    logic                  b_ground_reg;

    // state and result
    logic signed [DW-1:0]  integral_reg;
    logic                  out_valid_reg;
    logic [DW-1:0]         out_torque_reg;

    // stage a to b
    logic signed [2*DW-1:0]  p_prod;
    logic signed [ERR_W-1:0] err_raw;
    logic signed [ERR_W-1:0] err_lim;
    logic signed [EP_W-1:0]  edt_prod;
    logic signed [PT_W-1:0]  b_pterm_next;
    logic signed [ED_W-1:0]  b_edt_next;

    always_comb
    begin
        p_prod  = kp_reg * a_meas_reg;
        err_raw = ERR_W'(a_meas_reg) - ERR_W'(a_target_reg);
        err_lim = err_raw;
        if (pos_sat_reg && err_raw > 0)
            err_lim = '0;
        if (neg_sat_reg && err_raw < 0)
            err_lim = '0;
        edt_prod     = EP_W'(err_lim) * $signed({1'b0, a_dt_reg});
        b_pterm_next = p_prod[2*DW-1:FRAC_BITS];
        b_edt_next   = edt_prod[EP_W-1:srlc_pkg::DT_FRAC_BITS];
    end

    // stage b to result, integral update
    logic signed [2*DW-1:0] i_prod;
    logic signed [PT_W-1:0] iterm;
    logic signed [TQ_W-1:0] torque_sum;
    logic [DW-1:0]          torque_next;
    logic signed [IS_W-1:0] int_sum;
    logic signed [IS_W-1:0] clamp_pos;
    logic signed [IS_W-1:0] clamp_neg;
    logic signed [DW-1:0]   integral_next;
    logic                   int_upd;

    always_comb
    begin
        i_prod     = ki_reg * integral_reg;
        iterm      = i_prod[2*DW-1:FRAC_BITS];
        torque_sum = -TQ_W'(b_pterm_reg) - TQ_W'(iterm);
        if (torque_sum > TQ_W'(signed'({1'b0, {(DW-1){1'b1}}})))
            torque_next = {1'b0, {(DW-1){1'b1}}};
        else if (torque_sum < -TQ_W'(signed'({1'b0, 1'b1, {(DW-1){1'b0}}})))
            torque_next = {1'b1, {(DW-1){1'b0}}};
        else
            torque_next = torque_sum[DW-1:0];

        int_sum   = IS_W'(integral_reg) + IS_W'(b_edt_reg);
        clamp_pos = $signed(IS_W'(clamp_reg));
        clamp_neg = -clamp_pos;
        if (int_sum > clamp_pos)
            integral_next = clamp_pos[DW-1:0];
        else if (int_sum < clamp_neg)
            integral_next = clamp_neg[DW-1:0];
        else
            integral_next = int_sum[DW-1:0];

        int_upd = adv && b_valid_reg && !b_ground_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
        end
        else
        begin
            if (adv)
            begin
                a_valid_reg   <= s_axis_tvalid;
                b_valid_reg   <= a_valid_reg;
                out_valid_reg <= b_valid_reg;
            end
            if (int_upd)
                integral_reg <= integral_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_meas_reg     <= s_axis_tdata[31:0];
            a_target_reg   <= s_axis_tdata[63:32];
            a_dt_reg       <= s_axis_tdata[87:64];
            a_ground_reg   <= s_axis_tuser;
            b_pterm_reg    <= b_pterm_next;
            b_edt_reg      <= b_edt_next;
            b_ground_reg   <= a_ground_reg;
            out_torque_reg <= torque_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_torque_reg;

    // integral moves only when an airborne request leaves the product stage
    a_int_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !int_upd |=> $stable(integral_reg))
        else $error("integral changed without an update");

    a_b_follow: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> b_valid_reg == $past(a_valid_reg))
        else $error("product stage lost or invented a request");

    a_out_follow: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg == $past(b_valid_reg))
        else $error("result register lost or invented a request");

endmodule

### tb/sv/tb_servo_lqr_rate_controller_top.sv
module tb_servo_lqr_rate_controller_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = srlc_pkg::FRAC_BITS_DEF;
    localparam logic [srlc_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam logic signed [31:0] RATE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] RATE_MIN = 32'sh8000_0000;
    localparam logic [23:0] DT_MAX = 24'hFF_FFFF;
    localparam logic [30:0] CLAMP_MAX = 31'h7FFF_FFFF;
    localparam longint TORQUE_HI = 64'sh7FFF_FFFF;
    localparam longint TORQUE_LO = -64'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] meas;
        logic signed [31:0] target;
        logic [23:0]        dt;
        logic               grounded;
    } rate_req_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [srlc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [srlc_pkg::DATA_W-1:0] cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [87:0]       s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [srlc_pkg::DATA_W-1:0] m_axis_tdata;

    // controller copy kept in step with the block
    logic signed [31:0] kp_gain = '0;
    logic signed [31:0] ki_gain = '0;
    logic [30:0]        clamp_lim = srlc_pkg::CLAMP_RESET;
    logic               pos_sat = 1'b0;
    logic               neg_sat = 1'b0;
    logic signed [31:0] integ = '0;

    rate_req_t   rate_reqs[$];
    logic [31:0] torque_expect[$];
    rate_req_t   next_req;
    logic        req_taken = 1'b0;
    int          src_gap = 0;
    int          snk_stall = 0;
    logic        src_idle_on = 1'b0;
    logic        snk_idle_on = 1'b0;
    int          fail_count = 0;
    logic [31:0] want_torque;

    servo_lqr_rate_controller_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // torque from the old integral, then integral update and clamp
    function automatic logic [31:0] servo_step(logic signed [31:0] meas,
                                               logic signed [31:0] target,
                                               logic [23:0] dt, logic grounded);
        longint p_term;
        longint i_term;
        longint sum;
        longint err;
        longint next_i;
        longint lim;
        p_term = (longint'(kp_gain) * longint'(meas)) >>> FRAC;
        i_term = (longint'(ki_gain) * longint'(integ)) >>> FRAC;
        sum = -p_term - i_term;
        if (sum > TORQUE_HI)
            sum = TORQUE_HI;
        if (sum < TORQUE_LO)
            sum = TORQUE_LO;
        if (!grounded)
        begin
            err = longint'(meas) - longint'(target);
            if (pos_sat && err > 0)
                err = 0;
            if (neg_sat && err < 0)
                err = 0;
            next_i = longint'(integ)
                     + ((err * longint'({40'd0, dt})) >>> srlc_pkg::DT_FRAC_BITS);
            lim = longint'({33'd0, clamp_lim});
            if (next_i > lim)
                next_i = lim;
            if (next_i < -lim)
                next_i = -lim;
            integ = next_i[31:0];
        end
        return sum[31:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] pick_gain();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return RATE_MAX;
            2: return RATE_MIN;
            3: return $urandom;
            4: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
            default: return int'($urandom_range(0, 1 << 18)) - (1 << 17);
        endcase
    endfunction

    function automatic logic [30:0] pick_clamp();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CLAMP_MAX;
            2: return 31'($urandom);
            3: return srlc_pkg::CLAMP_RESET;
            default: return 31'($urandom_range(1, 1 << 20));
        endcase
    endfunction

    function automatic logic signed [31:0] pick_rate();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? RATE_MAX : RATE_MIN;
            1, 2: return $urandom;
            default: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
        endcase
    endfunction

    // bias 1 drives the error positive, bias 2 negative, 0 leaves it free
    function automatic rate_req_t pick_req(int bias);
        rate_req_t r;
        longint t;
        r.meas = pick_rate();
        if (bias == 0 || $urandom_range(0, 9) == 0)
            r.target = pick_rate();
        else
        begin
            t = longint'(r.meas) + (bias == 1 ? -1 : 1) * longint'($urandom_range(0, 1 << 20));
            if (t > TORQUE_HI)
                t = TORQUE_HI;
            if (t < TORQUE_LO)
                t = TORQUE_LO;
            r.target = t[31:0];
        end
        case ($urandom_range(0, 9))
            0: r.dt = '0;
            1: r.dt = DT_MAX;
            2, 3, 4: r.dt = 24'($urandom_range(0, 1 << 16));
            default: r.dt = 24'($urandom);
        endcase
        r.grounded = ($urandom_range(0, 4) == 0);
        return r;
    endfunction

    task automatic push_req(logic signed [31:0] meas, logic signed [31:0] target,
                            logic [23:0] dt, logic grounded);
        rate_req_t r;
        r.meas = meas;
        r.target = target;
        r.dt = dt;
        r.grounded = grounded;
        rate_reqs.push_back(r);
    endtask

    task automatic write_reg(logic [srlc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            srlc_pkg::REG_PROP_GAIN: kp_gain = value;
            srlc_pkg::REG_INT_GAIN:  ki_gain = value;
            srlc_pkg::REG_INT_CLAMP: clamp_lim = value[30:0];
            srlc_pkg::REG_POS_SAT:   pos_sat = value[0];
            srlc_pkg::REG_NEG_SAT:   neg_sat = value[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        #1;
    endtask

    // wait until every request is taken and every torque has come back
    task automatic drain();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (rate_reqs.size() != 0 || s_axis_tvalid || torque_expect.size() != 0);
        repeat (5) @(posedge clk);
        #1;
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || req_taken))
        begin
            if (src_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                src_gap <= src_gap - 1;
            end
            else if (rate_reqs.size() > 0)
            begin
                next_req = rate_reqs.pop_front();
                s_axis_tdata <= {next_req.dt, next_req.target, next_req.meas};
                s_axis_tuser <= next_req.grounded;
                s_axis_tvalid <= 1'b1;
                src_gap <= src_idle_on ? pick_gap() : 0;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result backpressure
    always @(negedge clk)
    begin
        if (snk_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            snk_stall <= snk_stall - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (snk_idle_on && $urandom_range(0, 3) == 0)
                snk_stall <= pick_gap();
        end
    end

    // predict on each taken request, check each torque
    always @(posedge clk)
    begin
        req_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            torque_expect.push_back(servo_step(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                               s_axis_tdata[87:64], s_axis_tuser));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (torque_expect.size() == 0)
            begin
                $error("torque_command with no request pending: got %0d",
                       $signed(m_axis_tdata));
                fail_count++;
            end
            else
            begin
                want_torque = torque_expect.pop_front();
                if (want_torque !== m_axis_tdata)
                begin
                    $error("torque_command mismatch: expected %0d, got %0d",
                           $signed(want_torque), $signed(m_axis_tdata));
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #30_000_000;
        $display("servo_lqr_rate_controller_top test failed");
        $finish;
    end

    initial
    begin
        int ph;
        int n;
        int bias;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #1;

        // reset settings: zero gains, integral runs into the default clamp
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        push_req(RATE_MAX, RATE_MIN, DT_MAX, 1'b0);
        push_req(RATE_MAX, RATE_MIN, DT_MAX, 1'b1);
        push_req(RATE_MIN, RATE_MAX, DT_MAX, 1'b0);
        push_req(RATE_MIN, RATE_MAX, 24'd0, 1'b0);
        push_req(32'sd0, 32'sd0, 24'd1, 1'b0);
        drain();

        // extreme gains, positive side blocked, spare index ignored
        write_reg(srlc_pkg::REG_PROP_GAIN, RATE_MIN);
        write_reg(srlc_pkg::REG_INT_GAIN, RATE_MAX);
        write_reg(srlc_pkg::REG_INT_CLAMP, {1'b0, CLAMP_MAX});
        write_reg(srlc_pkg::REG_POS_SAT, 32'd1);
        write_reg(REG_SPARE, 32'h0000_1234);
        push_req(RATE_MIN, 32'sd0, DT_MAX, 1'b0);
        push_req(RATE_MAX, RATE_MIN, DT_MAX, 1'b0);
        push_req(RATE_MIN, RATE_MAX, DT_MAX, 1'b0);
        push_req(RATE_MIN, RATE_MAX, DT_MAX, 1'b0);
        push_req(RATE_MAX, 32'sd0, 24'h80_0000, 1'b0);
        drain();

        // negative side blocked
        write_reg(srlc_pkg::REG_POS_SAT, 32'd0);
        write_reg(srlc_pkg::REG_NEG_SAT, 32'd1);
        write_reg(srlc_pkg::REG_INT_GAIN, RATE_MIN);
        push_req(RATE_MIN, RATE_MAX, DT_MAX, 1'b0);
        push_req(RATE_MAX, RATE_MIN, DT_MAX, 1'b0);
        push_req(RATE_MAX, RATE_MIN, DT_MAX, 1'b0);
        drain();

        // both flags: error forced to zero, integral only re-clamped
        write_reg(srlc_pkg::REG_POS_SAT, 32'd1);
        write_reg(srlc_pkg::REG_INT_CLAMP, 32'd1000);
        push_req(RATE_MAX, RATE_MIN, DT_MAX, 1'b0);
        push_req(RATE_MIN, RATE_MAX, DT_MAX, 1'b0);
        push_req(32'sd5, 32'sd5, DT_MAX, 1'b0);
        drain();

        // zero clamp holds the integral at zero
        write_reg(srlc_pkg::REG_POS_SAT, 32'd0);
        write_reg(srlc_pkg::REG_NEG_SAT, 32'd0);
        write_reg(srlc_pkg::REG_INT_CLAMP, 32'd0);
        push_req(RATE_MAX, RATE_MIN, DT_MAX, 1'b0);
        push_req(RATE_MIN, RATE_MAX, DT_MAX, 1'b0);
        push_req(RATE_MAX, 32'sd0, DT_MAX, 1'b0);
        drain();

        for (ph = 0; ph < 12; ph++)
        begin
            write_reg(srlc_pkg::REG_PROP_GAIN, pick_gain());
            write_reg(srlc_pkg::REG_INT_GAIN, pick_gain());
            write_reg(srlc_pkg::REG_INT_CLAMP, {1'b0, pick_clamp()});
            write_reg(srlc_pkg::REG_POS_SAT, {31'd0, $urandom_range(0, 3) == 0});
            write_reg(srlc_pkg::REG_NEG_SAT, {31'd0, $urandom_range(0, 3) == 0});
            src_idle_on = (ph % 4 != 1);
            snk_idle_on = (ph % 4 != 2);
            bias = ph % 3;
            for (n = 0; n < 162; n++)
            begin
                rate_reqs.push_back(pick_req(bias));
                // sender holds off mid-phase until the pipeline is empty
                if (ph == 5 && n == 80)
                    drain();
            end
            drain();
        end

        if (fail_count == 0)
            $display("servo_lqr_rate_controller_top test passed");
        else
            $display("servo_lqr_rate_controller_top test failed");
        $finish;
    end

endmodule

### sim.f
rtl/srlc_pkg.sv
rtl/servo_lqr_rate_controller_top.sv
tb/sv/tb_servo_lqr_rate_controller_top.sv
